@@ rtl/lcf_pkg.sv @@
package lcf_pkg;

    localparam int LEVEL_W     = 8;
    localparam int COLOUR_W    = 8;
    localparam int PERIOD_W    = 16;
    localparam int DUR_W       = 32;
    localparam int IN_CHANNELS = 4;
    localparam int NUM_CHANNELS_DEFAULT = 4;

    // Shared divider geometry
    localparam int DIV_W       = 32;
    localparam int DIV_SHORT_W = 16;
    localparam int DIVISOR_W   = 8;
    localparam int DIV_CNT_W   = 6;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(1);

    localparam logic [2:0] MODE_TICK         = 3'd0;
    localparam logic [2:0] MODE_LEVEL_TIMED  = 3'd1;
    localparam logic [2:0] MODE_LEVEL_RATE   = 3'd2;
    localparam logic [2:0] MODE_LEVEL_STOP   = 3'd3;
    localparam logic [2:0] MODE_COLOUR_START = 3'd4;
    localparam logic [2:0] MODE_COLOUR_STOP  = 3'd5;

    typedef struct packed {
        logic [2:0]          mode;
        logic [LEVEL_W-1:0]  level_target;
        logic [DUR_W-1:0]    fade_ms;
        logic [PERIOD_W-1:0] rate_ms;
        logic [COLOUR_W-1:0] colour_in_0;
        logic [COLOUR_W-1:0] colour_in_1;
        logic [COLOUR_W-1:0] colour_in_2;
        logic [COLOUR_W-1:0] colour_in_3;
    } cmd_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level_out;
        logic                level_changed;
        logic                level_busy;
        logic [COLOUR_W-1:0] colour_out_0;
        logic [COLOUR_W-1:0] colour_out_1;
        logic [COLOUR_W-1:0] colour_out_2;
        logic [COLOUR_W-1:0] colour_out_3;
        logic                colour_changed;
        logic                colour_busy;
    } res_t;

    typedef struct packed {
        logic start;
        logic short_op;
    } div_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_LEVEL,
        ST_DIV_COLOUR,
        ST_INTERP,
        ST_INTERP_WAIT,
        ST_RESULT
    } state_t;

    function automatic logic [COLOUR_W-1:0] in_colour(cmd_t c, logic [1:0] k);
        logic [COLOUR_W-1:0] v;
        case (k)
            2'd0:    v = c.colour_in_0;
            2'd1:    v = c.colour_in_1;
            2'd2:    v = c.colour_in_2;
            default: v = c.colour_in_3;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/lcf_div.sv @@
module lcf_div
    import lcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_cmd_t             cmd,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0]     q_reg, q_next;

    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (cmd.start)
        begin
            // short operands sit in the upper half so only their bits are walked
            busy_next = 1'b1;
            rem_next  = '0;
            den_next  = divisor;
            if (cmd.short_op)
            begin
                q_next   = {dividend[DIV_SHORT_W-1:0], {(DIV_W-DIV_SHORT_W){1'b0}}};
                cnt_next = DIV_CNT_W'(DIV_SHORT_W);
            end
            else
            begin
                q_next   = dividend;
                cnt_next = DIV_CNT_W'(DIV_W);
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, den_reg}) : trial[DIVISOR_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/light_level_and_colour_fader.sv @@
// Brightness fade and colour crossfade engine.
//
// Input channel (cmd_valid / cmd_stall / cmd): one transaction per command or
// per 1 ms tick. Output channel (res_valid / res_stall / res): exactly one
// result transaction per input transaction, in order.
//
// Each command is worked by a small sequencer around one shared restoring
// divider (one quotient bit per cycle). Ticks and simple commands need no
// divide; a timed level start or colour start that does not jump runs one
// 32-bit divide, and a tick that steps the crossfade short of its end runs
// one 16-bit divide per colour channel for the interpolation.
// One command is worked at a time (the next one is accepted in the cycle
// after the result is written); cmd_stall is high from accept until the
// result is in the register.
//
// The output register parts the two sides: a new command is taken while the
// previous result still waits. If res_stall holds the result, the following
// command finishes its work and then waits until the register frees up.
// Reset clears the level, all colour channels and both fades to zero.
module light_level_and_colour_fader
    import lcf_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    state_t state_reg, state_next;

    cmd_t              cmd_reg, cmd_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              lchg_reg, lchg_next;
    logic              cchg_reg, cchg_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic [LEVEL_W-1:0]  level_now_reg, level_now_next;
    logic [LEVEL_W-1:0]  level_goal_reg, level_goal_next;
    logic [PERIOD_W-1:0] level_period_reg, level_period_next;
    logic [PERIOD_W-1:0] level_elapsed_reg, level_elapsed_next;
    logic                level_active_reg, level_active_next;

    logic [COLOUR_W-1:0] colour_now_reg  [NUM_CHANNELS];
    logic [COLOUR_W-1:0] colour_now_next [NUM_CHANNELS];
    logic [COLOUR_W-1:0] colour_from_reg [NUM_CHANNELS];
    logic [COLOUR_W-1:0] colour_from_next[NUM_CHANNELS];
    logic [COLOUR_W-1:0] colour_goal_reg [NUM_CHANNELS];
    logic [COLOUR_W-1:0] colour_goal_next[NUM_CHANNELS];
    logic [COLOUR_W-1:0] steps_total_reg, steps_total_next;
    logic [COLOUR_W-1:0] steps_done_reg, steps_done_next;
    logic [PERIOD_W-1:0] colour_period_reg, colour_period_next;
    logic [PERIOD_W-1:0] colour_elapsed_reg, colour_elapsed_next;
    logic                colour_active_reg, colour_active_next;

    // shared divider
    div_cmd_t             div_cmd;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_q;

    // decode helpers
    logic [COLOUR_W-1:0] tgt [NUM_CHANNELS];
    logic [COLOUR_W-1:0] col_pad [IN_CHANNELS];
    logic [COLOUR_W-1:0] max_dist;
    logic [LEVEL_W-1:0]  level_dist;
    logic                level_jump;
    logic                colour_jump;
    logic                lvl_due, col_due;
    logic [PERIOD_W-1:0] lvl_el_inc, col_el_inc;
    logic [COLOUR_W-1:0] done_inc;
    logic                colour_final;
    logic                res_free;
    logic                last_ch;
    logic [PERIOD_W-1:0] div_period;

    // interpolation operands for the current channel
    logic [COLOUR_W-1:0] ch_from, ch_goal;
    logic                ch_neg;
    logic [COLOUR_W-1:0] ch_mag;
    logic [2*COLOUR_W-1:0] ch_prod;
    logic [COLOUR_W-1:0] ch_quot;

    lcf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Channels past the four input fields take target zero; output fields
    // past NUM_CHANNELS read zero.
    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_tgt
        if (i < IN_CHANNELS)
        begin : g_in
            assign tgt[i] = in_colour(cmd_reg, 2'(i));
        end
        else
        begin : g_zero
            assign tgt[i] = '0;
        end
    end

    for (genvar i = 0; i < IN_CHANNELS; i++)
    begin : g_pad
        if (i < NUM_CHANNELS)
        begin : g_ch
            assign col_pad[i] = colour_now_reg[i];
        end
        else
        begin : g_zero
            assign col_pad[i] = '0;
        end
    end

    // Decode conditions
    always_comb
    begin
        logic [COLOUR_W-1:0] d;
        max_dist = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            d = (colour_now_reg[i] > tgt[i]) ? colour_now_reg[i] - tgt[i]
                                              : tgt[i] - colour_now_reg[i];
            if (d > max_dist)
            begin
                max_dist = d;
            end
        end
    end

    assign level_dist = (level_now_reg > cmd_reg.level_target)
                      ? level_now_reg - cmd_reg.level_target
                      : cmd_reg.level_target - level_now_reg;
    assign level_jump = (cmd_reg.level_target == level_now_reg) ||
                        (cmd_reg.fade_ms == '0) || (cmd_reg.level_target == '0);
    assign colour_jump = (cmd_reg.fade_ms == '0) || (max_dist == '0);

    // Tick counters advance and saturate; a step is due once the period is reached
    assign lvl_el_inc = (level_elapsed_reg != PERIOD_MAX) ? level_elapsed_reg + 1'b1
                                                          : level_elapsed_reg;
    assign col_el_inc = (colour_elapsed_reg != PERIOD_MAX) ? colour_elapsed_reg + 1'b1
                                                           : colour_elapsed_reg;
    assign lvl_due = (lvl_el_inc >= level_period_reg);
    assign col_due = (col_el_inc >= colour_period_reg);
    assign done_inc = steps_done_reg + 1'b1;
    assign colour_final = (done_inc >= steps_total_reg) || (steps_total_reg == '0);

    assign res_free = !res_valid_reg || !res_stall;
    assign last_ch  = (ch_reg == CH_W'(NUM_CHANNELS - 1));

    // Clamp the divider quotient to a valid period
    assign div_period = (div_q > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX
                      : (div_q == '0)                ? PERIOD_MIN
                      : div_q[PERIOD_W-1:0];

    assign ch_from = colour_from_reg[ch_reg];
    assign ch_goal = colour_goal_reg[ch_reg];
    assign ch_neg  = (ch_goal < ch_from);
    assign ch_mag  = ch_neg ? ch_from - ch_goal : ch_goal - ch_from;
    assign ch_prod = ch_mag * steps_done_reg;
    assign ch_quot = div_q[COLOUR_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (cmd_reg.mode)
                    MODE_TICK:
                    begin
                        if (colour_active_reg && col_due && !colour_final)
                        begin
                            state_next = ST_INTERP;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                    MODE_LEVEL_TIMED:
                    begin
                        state_next = level_jump ? ST_RESULT : ST_DIV_LEVEL;
                    end
                    MODE_COLOUR_START:
                    begin
                        state_next = colour_jump ? ST_RESULT : ST_DIV_COLOUR;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_DIV_LEVEL, ST_DIV_COLOUR:
            begin
                if (div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_INTERP:
            begin
                state_next = ST_INTERP_WAIT;
            end
            ST_INTERP_WAIT:
            begin
                if (div_done)
                begin
                    state_next = last_ch ? ST_RESULT : ST_INTERP;
                end
            end
            ST_RESULT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        cmd_next            = cmd_reg;
        ch_next             = ch_reg;
        lchg_next           = lchg_reg;
        cchg_next           = cchg_reg;
        res_next            = res_reg;
        res_valid_next      = res_valid_reg;
        level_now_next      = level_now_reg;
        level_goal_next     = level_goal_reg;
        level_period_next   = level_period_reg;
        level_elapsed_next  = level_elapsed_reg;
        level_active_next   = level_active_reg;
        colour_now_next     = colour_now_reg;
        colour_from_next    = colour_from_reg;
        colour_goal_next    = colour_goal_reg;
        steps_total_next    = steps_total_reg;
        steps_done_next     = steps_done_reg;
        colour_period_next  = colour_period_reg;
        colour_elapsed_next = colour_elapsed_reg;
        colour_active_next  = colour_active_reg;
        div_cmd             = '0;
        div_dividend        = cmd_reg.fade_ms;
        div_divisor         = level_dist;

        // drop the result once the receiver takes it
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                end
            end
            ST_DECODE:
            begin
                lchg_next = 1'b0;
                cchg_next = 1'b0;
                case (cmd_reg.mode)
                    MODE_TICK:
                    begin
                        if (level_active_reg)
                        begin
                            level_elapsed_next = lvl_due ? '0 : lvl_el_inc;
                            if (lvl_due)
                            begin
                                lchg_next = 1'b1;
                                if (level_now_reg < level_goal_reg)
                                begin
                                    level_now_next = level_now_reg + 1'b1;
                                end
                                else if (level_now_reg > level_goal_reg)
                                begin
                                    level_now_next = level_now_reg - 1'b1;
                                end
                                if (level_now_next == level_goal_reg)
                                begin
                                    level_active_next = 1'b0;
                                end
                            end
                        end
                        if (colour_active_reg)
                        begin
                            colour_elapsed_next = col_due ? '0 : col_el_inc;
                            if (col_due)
                            begin
                                cchg_next       = 1'b1;
                                steps_done_next = done_inc;
                                ch_next         = '0;
                                if (colour_final)
                                begin
                                    colour_now_next    = colour_goal_reg;
                                    colour_active_next = 1'b0;
                                end
                            end
                        end
                    end
                    MODE_LEVEL_TIMED:
                    begin
                        level_active_next = 1'b0;
                        if (level_jump)
                        begin
                            level_now_next = cmd_reg.level_target;
                            lchg_next      = 1'b1;
                        end
                        else
                        begin
                            level_goal_next    = cmd_reg.level_target;
                            level_elapsed_next = '0;
                            div_cmd.start      = 1'b1;
                        end
                    end
                    MODE_LEVEL_RATE:
                    begin
                        level_active_next = 1'b0;
                        if (cmd_reg.level_target != level_now_reg)
                        begin
                            level_goal_next    = cmd_reg.level_target;
                            level_period_next  = (cmd_reg.rate_ms == '0) ? PERIOD_MIN
                                                                         : cmd_reg.rate_ms;
                            level_elapsed_next = '0;
                            level_active_next  = 1'b1;
                        end
                    end
                    MODE_LEVEL_STOP:
                    begin
                        level_active_next = 1'b0;
                    end
                    MODE_COLOUR_START:
                    begin
                        colour_active_next = 1'b0;
                        colour_from_next   = colour_now_reg;
                        colour_goal_next   = tgt;
                        if (colour_jump)
                        begin
                            colour_now_next = tgt;
                            cchg_next       = 1'b1;
                        end
                        else
                        begin
                            steps_total_next    = max_dist;
                            steps_done_next     = '0;
                            colour_elapsed_next = '0;
                            div_divisor         = max_dist;
                            div_cmd.start       = 1'b1;
                        end
                    end
                    MODE_COLOUR_STOP:
                    begin
                        colour_active_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DIV_LEVEL:
            begin
                if (div_done)
                begin
                    level_period_next = div_period;
                    level_active_next = 1'b1;
                end
            end
            ST_DIV_COLOUR:
            begin
                if (div_done)
                begin
                    colour_period_next = div_period;
                    colour_active_next = 1'b1;
                end
            end
            ST_INTERP:
            begin
                // |span| * steps / total, sign applied after the divide
                div_cmd.start    = 1'b1;
                div_cmd.short_op = 1'b1;
                div_dividend     = DIV_W'(ch_prod);
                div_divisor      = steps_total_reg;
            end
            ST_INTERP_WAIT:
            begin
                if (div_done)
                begin
                    colour_now_next[ch_reg] = ch_neg ? ch_from - ch_quot : ch_from + ch_quot;
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (res_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next.level_out      = level_now_reg;
                    res_next.level_changed  = lchg_reg;
                    res_next.level_busy     = level_active_reg;
                    res_next.colour_out_0   = col_pad[0];
                    res_next.colour_out_1   = col_pad[1];
                    res_next.colour_out_2   = col_pad[2];
                    res_next.colour_out_3   = col_pad[3];
                    res_next.colour_changed = cchg_reg;
                    res_next.colour_busy    = colour_active_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            ch_reg             <= '0;
            lchg_reg           <= 1'b0;
            cchg_reg           <= 1'b0;
            res_valid_reg      <= 1'b0;
            level_now_reg      <= '0;
            level_goal_reg     <= '0;
            level_period_reg   <= '0;
            level_elapsed_reg  <= '0;
            level_active_reg   <= 1'b0;
            steps_total_reg    <= '0;
            steps_done_reg     <= '0;
            colour_period_reg  <= '0;
            colour_elapsed_reg <= '0;
            colour_active_reg  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                colour_now_reg[i]  <= '0;
                colour_from_reg[i] <= '0;
                colour_goal_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg          <= state_next;
            ch_reg             <= ch_next;
            lchg_reg           <= lchg_next;
            cchg_reg           <= cchg_next;
            res_valid_reg      <= res_valid_next;
            level_now_reg      <= level_now_next;
            level_goal_reg     <= level_goal_next;
            level_period_reg   <= level_period_next;
            level_elapsed_reg  <= level_elapsed_next;
            level_active_reg   <= level_active_next;
            steps_total_reg    <= steps_total_next;
            steps_done_reg     <= steps_done_next;
            colour_period_reg  <= colour_period_next;
            colour_elapsed_reg <= colour_elapsed_next;
            colour_active_reg  <= colour_active_next;
            colour_now_reg     <= colour_now_next;
            colour_from_reg    <= colour_from_next;
            colour_goal_reg    <= colour_goal_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A running brightness fade always has a nonzero step period.
    a_level_period: assert property (@(posedge clk) disable iff (!rst_n)
        level_active_reg |-> (level_period_reg != '0))
        else $error("level fade running with zero period");

    // A running crossfade has steps left and a nonzero period.
    a_colour_steps: assert property (@(posedge clk) disable iff (!rst_n)
        colour_active_reg |-> (steps_done_reg < steps_total_reg) &&
                              (colour_period_reg != '0))
        else $error("crossfade running without steps left");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_LEVEL) || (state_reg == ST_DIV_COLOUR) ||
                     (state_reg == ST_INTERP_WAIT))
        else $error("divider result with no consumer");

    // Leaving the result state always leaves a valid result behind.
    a_result_written: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT) && (state_next == ST_IDLE) |=> res_valid_reg)
        else $error("result state left without a result");

endmodule

@@ sim/light_level_and_colour_fader_test.sv @@
`timescale 1ns / 100ps

module light_level_and_colour_fader_test;
    import lcf_pkg::*;

    // Modes 6 and 7 are spare codes: the block must leave all state alone.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1600;
    // The slowest transaction is a crossfade step; even with heavy stalling
    // all 1600 items finish well inside the limit.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_REPORTS  = 40;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    int give_idle_pct;
    int take_idle_pct;
    int cycle_count;

    // Track the fader state and keep the outputs each accepted command must
    // produce, oldest first.
    class fader_scoreboard;
        logic [LEVEL_W-1:0]  bright;
        logic [LEVEL_W-1:0]  bright_goal;
        logic [PERIOD_W-1:0] bright_period;
        logic [PERIOD_W-1:0] bright_ticks;
        logic                bright_run;
        logic [COLOUR_W-1:0] tint [IN_CHANNELS];
        logic [COLOUR_W-1:0] tint_from [IN_CHANNELS];
        logic [COLOUR_W-1:0] tint_goal [IN_CHANNELS];
        logic [7:0]          tint_steps;
        logic [7:0]          tint_done;
        logic [PERIOD_W-1:0] tint_period;
        logic [PERIOD_W-1:0] tint_ticks;
        logic                tint_run;
        res_t                due_outputs [$];
        int                  mismatches;

        function new();
            bright        = '0;
            bright_goal   = '0;
            bright_period = '0;
            bright_ticks  = '0;
            bright_run    = 1'b0;
            foreach (tint[k])
            begin
                tint[k]      = '0;
                tint_from[k] = '0;
                tint_goal[k] = '0;
            end
            tint_steps  = '0;
            tint_done   = '0;
            tint_period = '0;
            tint_ticks  = '0;
            tint_run    = 1'b0;
            mismatches  = 0;
        endfunction

        // Divide the duration over the step count; clamp to 1..65535 ms.
        function logic [PERIOD_W-1:0] step_period(logic [DUR_W-1:0] dur, logic [31:0] steps);
            logic [DUR_W-1:0] p;
            p = (steps == 0) ? dur : dur / steps;
            if (p > DUR_W'(PERIOD_MAX))
                p = DUR_W'(PERIOD_MAX);
            if (p < 1)
                p = 1;
            return p[PERIOD_W-1:0];
        endfunction

        // Advance a fade's millisecond count; report whether a step is due.
        function bit tick_due(inout logic [PERIOD_W-1:0] ticks, input logic [PERIOD_W-1:0] period);
            if (ticks != PERIOD_MAX)
                ticks = ticks + 1'b1;
            if (ticks >= period)
            begin
                ticks = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Apply one accepted command transaction and queue the outputs it yields.
        function void note_command(cmd_t c);
            logic                lvl_chg;
            logic                col_chg;
            logic [7:0]          reach;
            logic [7:0]          widest;
            logic [COLOUR_W-1:0] aim [IN_CHANNELS];
            int                  span;
            int                  mid;
            res_t                r;
            lvl_chg = 1'b0;
            col_chg = 1'b0;
            aim = '{c.colour_in_0, c.colour_in_1, c.colour_in_2, c.colour_in_3};
            case (c.mode)
                MODE_TICK:
                begin
                    if (bright_run)
                    begin
                        if (tick_due(bright_ticks, bright_period))
                        begin
                            if (bright < bright_goal)
                                bright = bright + 1'b1;
                            else if (bright > bright_goal)
                                bright = bright - 1'b1;
                            if (bright == bright_goal)
                                bright_run = 1'b0;
                            lvl_chg = 1'b1;
                        end
                    end
                    if (tint_run)
                    begin
                        if (tick_due(tint_ticks, tint_period))
                        begin
                            tint_done = tint_done + 1'b1;
                            if (tint_done >= tint_steps || tint_steps == 0)
                            begin
                                tint     = tint_goal;
                                tint_run = 1'b0;
                            end
                            else
                            begin
                                // Interpolate from the start value; signed divide
                                // truncates toward zero.
                                foreach (tint[k])
                                begin
                                    span    = int'(tint_goal[k]) - int'(tint_from[k]);
                                    mid     = int'(tint_from[k]) +
                                              span * int'(tint_done) / int'(tint_steps);
                                    tint[k] = mid[7:0];
                                end
                            end
                            col_chg = 1'b1;
                        end
                    end
                end
                MODE_LEVEL_TIMED:
                begin
                    bright_run = 1'b0;
                    if (c.level_target == bright || c.fade_ms == 0 || c.level_target == 0)
                    begin
                        bright  = c.level_target;
                        lvl_chg = 1'b1;
                    end
                    else
                    begin
                        reach = (bright > c.level_target) ? bright - c.level_target
                                                          : c.level_target - bright;
                        bright_goal   = c.level_target;
                        bright_period = step_period(c.fade_ms, 32'(reach));
                        bright_ticks  = '0;
                        bright_run    = 1'b1;
                    end
                end
                MODE_LEVEL_RATE:
                begin
                    bright_run = 1'b0;
                    if (c.level_target != bright)
                    begin
                        bright_goal   = c.level_target;
                        bright_period = (c.rate_ms == 0) ? PERIOD_MIN : c.rate_ms;
                        bright_ticks  = '0;
                        bright_run    = 1'b1;
                    end
                end
                MODE_LEVEL_STOP:
                    bright_run = 1'b0;
                MODE_COLOUR_START:
                begin
                    tint_run = 1'b0;
                    widest   = '0;
                    foreach (tint[k])
                    begin
                        reach = (tint[k] > aim[k]) ? tint[k] - aim[k] : aim[k] - tint[k];
                        if (reach > widest)
                            widest = reach;
                        tint_from[k] = tint[k];
                        tint_goal[k] = aim[k];
                    end
                    if (c.fade_ms == 0 || widest == 0)
                    begin
                        tint    = tint_goal;
                        col_chg = 1'b1;
                    end
                    else
                    begin
                        tint_steps  = widest;
                        tint_done   = '0;
                        tint_period = step_period(c.fade_ms, 32'(widest));
                        tint_ticks  = '0;
                        tint_run    = 1'b1;
                    end
                end
                MODE_COLOUR_STOP:
                    tint_run = 1'b0;
                default:
                    ;
            endcase
            r.level_out      = bright;
            r.level_changed  = lvl_chg;
            r.level_busy     = bright_run;
            r.colour_out_0   = tint[0];
            r.colour_out_1   = tint[1];
            r.colour_out_2   = tint[2];
            r.colour_out_3   = tint[3];
            r.colour_changed = col_chg;
            r.colour_busy    = tint_run;
            due_outputs.push_back(r);
        endfunction

        task report(string what);
            if (mismatches < MAX_REPORTS)
                $display("%0t mismatch: %s", $time, what);
            mismatches++;
        endtask

        task compare(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        // Check one accepted result transaction against the oldest expectation.
        task check_result(res_t got);
            res_t want;
            if (due_outputs.size() == 0)
            begin
                report("result transaction with nothing outstanding");
                return;
            end
            want = due_outputs.pop_front();
            compare("level_out", got.level_out, want.level_out);
            compare("level_changed", got.level_changed, want.level_changed);
            compare("level_busy", got.level_busy, want.level_busy);
            compare("colour_out_0", got.colour_out_0, want.colour_out_0);
            compare("colour_out_1", got.colour_out_1, want.colour_out_1);
            compare("colour_out_2", got.colour_out_2, want.colour_out_2);
            compare("colour_out_3", got.colour_out_3, want.colour_out_3);
            compare("colour_changed", got.colour_changed, want.colour_changed);
            compare("colour_busy", got.colour_busy, want.colour_busy);
        endtask
    endclass

    fader_scoreboard sb;

    light_level_and_colour_fader dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random; the rate follows the current phase.
    initial
    begin
        res_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            res_stall <= ($urandom_range(99) < take_idle_pct);
        end
    end

    // Watch both channels. Check results before noting the command of the
    // same edge: a result can never belong to a command accepted just now.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                sb.check_result(res);
            if (cmd_valid && !cmd_stall)
                sb.note_command(cmd);
        end
    end

    // Give up if the run hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Offer one command transaction and hold it until accepted. Leave valid
    // high afterwards so a back-to-back transaction needs no extra edge.
    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(99) < give_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Build a command from its fields; hues holds channel 0 in the top byte.
    task automatic issue(input logic [2:0] mode, input logic [7:0] lvl,
                         input logic [31:0] dur, input logic [15:0] rate,
                         input logic [31:0] hues);
        cmd_t c;
        c.mode         = mode;
        c.level_target = lvl;
        c.fade_ms      = dur;
        c.rate_ms      = rate;
        c.colour_in_0  = hues[31:24];
        c.colour_in_1  = hues[23:16];
        c.colour_in_2  = hues[15:8];
        c.colour_in_3  = hues[7:0];
        send_cmd(c);
    endtask

    initial
    begin
        cmd_t c;
        int   pick;
        sb = new();
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        give_idle_pct = 36;
        take_idle_pct = 48;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: spare modes carry all-ones and all-zeros noise.
        issue(MODE_SPARE_LO, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        issue(MODE_SPARE_HI, 8'h00, 32'h0, 16'h0, 32'h0);
        // Jump on zero duration, on an equal target, and on a target of zero.
        issue(MODE_LEVEL_TIMED, 8'd255, 32'd0, 16'd0, 32'h0);
        issue(MODE_LEVEL_TIMED, 8'd255, 32'd1000, 16'd0, 32'h0);
        issue(MODE_LEVEL_TIMED, 8'd0, 32'd1000, 16'd0, 32'h0);
        // Longest duration saturates the step period; then stop it.
        issue(MODE_LEVEL_TIMED, 8'd255, 32'hFFFF_FFFF, 16'd0, 32'h0);
        issue(MODE_TICK, 8'd0, 32'd0, 16'd0, 32'h0);
        issue(MODE_LEVEL_STOP, 8'd0, 32'd0, 16'd0, 32'h0);
        // Duration shorter than the distance clamps the period to 1 ms.
        issue(MODE_LEVEL_TIMED, 8'd10, 32'd3, 16'd0, 32'h0);
        issue(MODE_TICK, 8'd0, 32'd0, 16'd0, 32'h0);
        issue(MODE_TICK, 8'd0, 32'd0, 16'd0, 32'h0);
        // Rate start onto the current level only stops the fade.
        issue(MODE_LEVEL_RATE, 8'd2, 32'd0, 16'd7, 32'h0);
        // Zero rate runs at 1 ms per step.
        issue(MODE_LEVEL_RATE, 8'd4, 32'd0, 16'd0, 32'h0);
        issue(MODE_TICK, 8'd0, 32'd0, 16'd0, 32'h0);
        issue(MODE_LEVEL_RATE, 8'd0, 32'd0, 16'hFFFF, 32'h0);
        // Crossfade: instant on zero duration, instant with no distance,
        // saturated period, stop, then a real crossfade with mixed directions.
        issue(MODE_COLOUR_START, 8'd0, 32'd0, 16'd0, 32'hFF00_8001);
        issue(MODE_COLOUR_START, 8'd0, 32'd500, 16'd0, 32'hFF00_8001);
        issue(MODE_COLOUR_START, 8'd0, 32'hFFFF_FFFF, 16'd0, 32'h00FF_00FF);
        issue(MODE_COLOUR_STOP, 8'd0, 32'd0, 16'd0, 32'h0);
        issue(MODE_COLOUR_START, 8'd0, 32'd300, 16'd0, 32'h0AC8_034D);
        repeat (4) issue(MODE_TICK, 8'd0, 32'd0, 16'd0, 32'h0);
        issue(MODE_LEVEL_STOP, 8'd0, 32'd0, 16'd0, 32'h0);

        // Random part: mostly ticks so fades actually progress, starts with
        // short durations and nearby targets so many fades run to the end,
        // and a share of full-range noise.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                give_idle_pct = 48;
                take_idle_pct = 36;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                give_idle_pct = 0;
                take_idle_pct = 0;
            end
            c.level_target = 8'($urandom);
            c.fade_ms      = $urandom;
            c.rate_ms      = 16'($urandom);
            c.colour_in_0  = 8'($urandom);
            c.colour_in_1  = 8'($urandom);
            c.colour_in_2  = 8'($urandom);
            c.colour_in_3  = 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 62)
                c.mode = MODE_TICK;
            else if (pick < 70)
            begin
                c.mode = MODE_LEVEL_TIMED;
                if ($urandom_range(1))
                    c.level_target = sb.bright + 8'($urandom_range(10)) - 8'd5;
                if ($urandom_range(3) != 0)
                    c.fade_ms = $urandom_range(800);
                if ($urandom_range(15) == 0)
                    c.fade_ms = '0;
            end
            else if (pick < 77)
            begin
                c.mode = MODE_LEVEL_RATE;
                if ($urandom_range(1))
                    c.level_target = sb.bright + 8'($urandom_range(10)) - 8'd5;
                if ($urandom_range(3) != 0)
                    c.rate_ms = 16'($urandom_range(4));
            end
            else if (pick < 80)
                c.mode = MODE_LEVEL_STOP;
            else if (pick < 90)
            begin
                c.mode = MODE_COLOUR_START;
                if ($urandom_range(1))
                begin
                    c.colour_in_0 = sb.tint[0] + 8'($urandom_range(8)) - 8'd4;
                    c.colour_in_1 = sb.tint[1] + 8'($urandom_range(8)) - 8'd4;
                    c.colour_in_2 = sb.tint[2] + 8'($urandom_range(8)) - 8'd4;
                    c.colour_in_3 = sb.tint[3] + 8'($urandom_range(8)) - 8'd4;
                end
                if ($urandom_range(3) != 0)
                    c.fade_ms = $urandom_range(60);
                if ($urandom_range(15) == 0)
                    c.fade_ms = '0;
            end
            else if (pick < 94)
                c.mode = MODE_COLOUR_STOP;
            else
                c.mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
            send_cmd(c);
        end
        cmd_valid <= 1'b0;

        // Drain: wait for every expected result, then watch for strays.
        while (sb.due_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lcf_pkg.sv
rtl/lcf_div.sv
rtl/light_level_and_colour_fader.sv
sim/light_level_and_colour_fader_test.sv
